### hw/rtl/bsm_pkg.sv
package bsm_pkg;

   // Field widths
   localparam int FUNC_W      = 3;
   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int SEL_W       = 2;
   localparam int OFFSET_W    = 19;
   localparam int CHR_OFF_W   = 18;
   localparam int BANK_W      = 8;
   localparam int PRG_BANK_W  = 6;
   localparam int NUM_BANKS   = 8;
   localparam int BANK_IDX_W  = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 6;

   // Parameter defaults
   localparam int PRG_ADDR_BITS_DEF = 19;
   localparam int CHR_ADDR_BITS_DEF = 18;

   // Bus function codes
   localparam logic [FUNC_W-1:0] FUNC_CPU_READ  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_CPU_WRITE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PPU_READ  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PPU_WRITE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SCANLINE  = 3'd4;

   // Memory select codes
   localparam logic [SEL_W-1:0] SEL_NONE    = 2'd0;
   localparam logic [SEL_W-1:0] SEL_PRG_ROM = 2'd1;
   localparam logic [SEL_W-1:0] SEL_PRG_RAM = 2'd2;
   localparam logic [SEL_W-1:0] SEL_CHR     = 2'd3;

   // Register group codes (CPU address bits 14:13 at 8000h and above)
   localparam logic [1:0] GRP_BANK   = 2'd0;
   localparam logic [1:0] GRP_MIRROR = 2'd1;
   localparam logic [1:0] GRP_RELOAD = 2'd2;
   localparam logic [1:0] GRP_IRQ    = 2'd3;

   // PRG window codes
   localparam logic [1:0] WIN_8000 = 2'd0;
   localparam logic [1:0] WIN_A000 = 2'd1;
   localparam logic [1:0] WIN_C000 = 2'd2;
   localparam logic [1:0] WIN_E000 = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRG_BANK_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_AT_RESET = 1'd1;

   localparam logic [PRG_BANK_W-1:0] PRG_BANK_COUNT_RST = 6'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] bus_addr;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [SEL_W-1:0]    mem_select;
      logic [OFFSET_W-1:0] mem_offset;
      logic                mem_write;
      logic                mirror_horizontal;
      logic                irq_line;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } cfg_wr_type;

endpackage

### hw/rtl/bsm_core.sv
module bsm_core #(
   parameter int PRG_ADDR_BITS = bsm_pkg::PRG_ADDR_BITS_DEF,
   parameter int CHR_ADDR_BITS = bsm_pkg::CHR_ADDR_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  bsm_pkg::req_type   item,
   input  bsm_pkg::cfg_wr_type cfg,
   output bsm_pkg::rsp_type   result
);
   import bsm_pkg::*;

   // Offset masks from the memory address widths
   localparam logic [OFFSET_W:0]    PRG_ONE  = (OFFSET_W+1)'(1) << PRG_ADDR_BITS;
   localparam logic [OFFSET_W-1:0]  PRG_MASK = PRG_ONE[OFFSET_W-1:0] - OFFSET_W'(1);
   localparam logic [CHR_OFF_W:0]   CHR_ONE  = (CHR_OFF_W+1)'(1) << CHR_ADDR_BITS;
   localparam logic [CHR_OFF_W-1:0] CHR_MASK = CHR_ONE[CHR_OFF_W-1:0] - CHR_OFF_W'(1);

   // Mapper state
   logic [BANK_W-1:0]     bank_regs_ff [NUM_BANKS];
   logic [BANK_IDX_W-1:0] reg_select_ff, reg_select_in;
   logic                  prg_swap_mode_ff, prg_swap_mode_in;
   logic                  chr_invert_ff, chr_invert_in;
   logic                  mirror_state_ff, mirror_state_in;
   logic [BANK_W-1:0]     scan_counter_ff, scan_counter_in;
   logic [BANK_W-1:0]     scan_reload_ff, scan_reload_in;
   logic                  irq_enable_ff, irq_enable_in;
   logic                  irq_pending_ff, irq_pending_in;
   logic [PRG_BANK_W-1:0] rom_count_ff, rom_count_in;

   logic                  bank_we;
   logic [BANK_W-1:0]     tick_count;

   // Decode helpers
   logic                  odd;
   logic [1:0]            group;
   logic                  reg_wr;
   logic                  tick;
   logic [PRG_BANK_W-1:0] dbl, last_bank, second_bank, r6, rom_page;
   logic [2:0]            chr_win;
   logic [BANK_IDX_W-1:0] chr_idx;
   logic [BANK_W-1:0]     chr_reg, pat_page;
   logic [OFFSET_W-1:0]   prg_off;
   logic [CHR_OFF_W-1:0]  chr_off;

   assign odd    = item.bus_addr[0];
   assign group  = item.bus_addr[14:13];
   assign reg_wr = item_valid && (item.func == FUNC_CPU_WRITE) && item.bus_addr[15];
   assign tick   = item_valid && (item.func == FUNC_SCANLINE);

   // PRG window translation: fixed banks wrap modulo 64
   assign dbl         = {rom_count_ff[PRG_BANK_W-2:0], 1'b0};
   assign last_bank   = dbl - PRG_BANK_W'(1);
   assign second_bank = dbl - PRG_BANK_W'(2);
   assign r6          = bank_regs_ff[6][PRG_BANK_W-1:0];

   always_comb begin
      case (item.bus_addr[14:13])
         WIN_8000: rom_page = prg_swap_mode_ff ? second_bank : r6;
         WIN_A000: rom_page = bank_regs_ff[7][PRG_BANK_W-1:0];
         WIN_C000: rom_page = prg_swap_mode_ff ? r6 : second_bank;
         WIN_E000: rom_page = last_bank;
         default:  rom_page = last_bank;
      endcase
   end

   assign prg_off = {rom_page, item.bus_addr[12:0]} & PRG_MASK;

   // CHR window translation: 2 KB pairs use R0/R1 with bit 0 from the window
   assign chr_win  = item.bus_addr[12:10] ^ {chr_invert_ff, 2'b00};
   assign chr_idx  = chr_win[2] ? (chr_win - 3'd2) : {2'b00, chr_win[1]};
   assign chr_reg  = bank_regs_ff[chr_idx];
   assign pat_page = chr_win[2] ? chr_reg : {chr_reg[BANK_W-1:1], chr_win[0]};
   assign chr_off  = {pat_page, item.bus_addr[9:0]} & CHR_MASK;

   // Scanline counter step
   assign tick_count = (scan_counter_ff == '0) ? scan_reload_ff
                                                : scan_counter_ff - BANK_W'(1);

   // Next state
   always_comb begin
      reg_select_in     = reg_select_ff;
      prg_swap_mode_in  = prg_swap_mode_ff;
      chr_invert_in     = chr_invert_ff;
      mirror_state_in   = mirror_state_ff;
      scan_counter_in   = scan_counter_ff;
      scan_reload_in    = scan_reload_ff;
      irq_enable_in     = irq_enable_ff;
      irq_pending_in    = irq_pending_ff;
      rom_count_in      = rom_count_ff;
      bank_we           = 1'b0;

      if (reg_wr) begin
         case (group)
            GRP_BANK: begin
               if (odd) begin
                  bank_we = 1'b1;
               end else begin
                  reg_select_in    = item.write_data[2:0];
                  prg_swap_mode_in = item.write_data[6];
                  chr_invert_in    = item.write_data[7];
               end
            end
            GRP_MIRROR: begin
               if (!odd) mirror_state_in = item.write_data[0];
            end
            GRP_RELOAD: begin
               if (odd) scan_counter_in = '0;
               else     scan_reload_in  = item.write_data;
            end
            GRP_IRQ: begin
               if (odd) begin
                  irq_enable_in = 1'b1;
               end else begin
                  irq_enable_in  = 1'b0;
                  irq_pending_in = 1'b0;
               end
            end
            default: ;
         endcase
      end

      if (tick) begin
         scan_counter_in = tick_count;
         if (tick_count == '0 && irq_enable_ff) irq_pending_in = 1'b1;
      end

      // Config writes must arrive only while the pipeline is empty; the block itself does not enforce this
      if (cfg.valid) begin
         case (cfg.index)
            CSR_PRG_BANK_COUNT:  rom_count_in    = cfg.data;
            CSR_MIRROR_AT_RESET: mirror_state_in = cfg.data[0];
            default: ;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BANKS; i++) begin
            bank_regs_ff[i] <= '0;
         end
         bank_regs_ff[7]   <= BANK_W'(1);
         reg_select_ff     <= '0;
         prg_swap_mode_ff  <= 1'b0;
         chr_invert_ff     <= 1'b0;
         mirror_state_ff   <= 1'b0;
         scan_counter_ff   <= '0;
         scan_reload_ff    <= '0;
         irq_enable_ff     <= 1'b0;
         irq_pending_ff    <= 1'b0;
         rom_count_ff      <= PRG_BANK_COUNT_RST;
      end else begin
         if (bank_we) bank_regs_ff[reg_select_ff] <= item.write_data;
         reg_select_ff     <= reg_select_in;
         prg_swap_mode_ff  <= prg_swap_mode_in;
         chr_invert_ff     <= chr_invert_in;
         mirror_state_ff   <= mirror_state_in;
         scan_counter_ff   <= scan_counter_in;
         scan_reload_ff    <= scan_reload_in;
         irq_enable_ff     <= irq_enable_in;
         irq_pending_ff    <= irq_pending_in;
         rom_count_ff      <= rom_count_in;
      end
   end

   // Result for the current item; mirroring and IRQ include this item's update, other mode changes apply to later items
   always_comb begin
      result.mem_select        = SEL_NONE;
      result.mem_offset        = '0;
      result.mem_write         = 1'b0;
      result.mirror_horizontal = mirror_state_in;
      result.irq_line          = irq_pending_in;
      case (item.func) inside
         FUNC_CPU_READ, FUNC_CPU_WRITE: begin
            if (item.bus_addr[15:13] == 3'b011) begin
               result.mem_select = SEL_PRG_RAM;
               result.mem_offset = {6'd0, item.bus_addr[12:0]};
               result.mem_write  = item.func[0];
            end else if (item.bus_addr[15] && item.func == FUNC_CPU_READ) begin
               result.mem_select = SEL_PRG_ROM;
               result.mem_offset = prg_off;
            end
         end
         FUNC_PPU_READ, FUNC_PPU_WRITE: begin
            if (item.bus_addr[15:13] == 3'b000) begin
               result.mem_select = SEL_CHR;
               result.mem_offset = {1'b0, chr_off};
               result.mem_write  = item.func[0];
            end
         end
         default: ;
      endcase
   end

endmodule

### hw/rtl/bank_switch_mapper_with_scanline_irq.sv
// Pipeline: a req transfer enters the input register, then the result register, which offers the rsp transfer.
// Throughput: one transfer per cycle unless rsp_stall holds the result stage; the translation
// and the mapper state update are a single combinational pass between the two registers.
// Reset (synchronous, active high) empties both stages, R7 to one, other banks and
// IRQ state to zero, mirroring vertical, PRG bank count two. No clearing pass.
module bank_switch_mapper_with_scanline_irq #(
   parameter int PRG_ADDR_BITS = bsm_pkg::PRG_ADDR_BITS_DEF,
   parameter int CHR_ADDR_BITS = bsm_pkg::CHR_ADDR_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bsm_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bsm_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bsm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bsm_pkg::CSR_DATA_W-1:0]        csr_data
);
   import bsm_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    result;
   logic       advance;
   logic       req_xfer;
   cfg_wr_type cfg;

   // Result stage frees when empty or its transfer completes
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   assign csr_ready = 1'b1;
   assign cfg.valid = csr_valid;
   assign cfg.index = csr_index;
   assign cfg.data  = csr_data;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) s1_item_ff <= req_data;
      if (advance && s1_valid_ff) rsp_data_ff <= result;
   end

   bsm_core #(
      .PRG_ADDR_BITS (PRG_ADDR_BITS),
      .CHR_ADDR_BITS (CHR_ADDR_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff && advance),
      .item       (s1_item_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Input side stalls only when its register holds an item
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall with empty input stage");

   // A held item moves to the result stage once that stage is free
   a_item_advances: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !(rsp_valid_ff && rsp_stall)) |=> rsp_valid_ff)
      else $error("item lost between stages");

   // No memory selected means no offset and no write strobe
   a_none_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.mem_select == SEL_NONE) |->
         (rsp_data.mem_offset == '0 && !rsp_data.mem_write))
      else $error("unselected result carries offset or write");

   // PRG ROM is never written
   a_rom_read_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.mem_select == SEL_PRG_ROM) |-> !rsp_data.mem_write)
      else $error("write strobe on PRG ROM");
`endif

endmodule

### sim/tb_bank_switch_mapper_with_scanline_irq.sv
module tb_bank_switch_mapper_with_scanline_irq;
   import bsm_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int MAX_REPORTS = 40;
   localparam int PRG_BITS    = PRG_ADDR_BITS_DEF;
   localparam int CHR_BITS    = CHR_ADDR_BITS_DEF;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   bank_switch_mapper_with_scanline_irq DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the mapper state
   logic [BANK_W-1:0]     bank_file [NUM_BANKS];
   logic [BANK_IDX_W-1:0] bank_sel;
   logic                  prg_swapped;
   logic                  chr_inverted;
   logic                  mirror_h;
   logic [7:0]            line_count;
   logic [7:0]            line_reload;
   logic                  irq_armed;
   logic                  irq_raised;
   logic [PRG_BANK_W-1:0] rom_count_cfg;

   rsp_type expected_rsp[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      items_sent = 0;

   // Sender and receiver pacing
   bit gaps_on = 1'b0;
   int burst_left = 0;
   int stall_pct = 0;
   int hold_off = 0;

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic void reset_shadow();
      foreach (bank_file[i]) bank_file[i] = '0;
      bank_file[7]  = 8'd1;
      bank_sel      = '0;
      prg_swapped   = 1'b0;
      chr_inverted  = 1'b0;
      mirror_h      = 1'b0;
      line_count    = '0;
      line_reload   = '0;
      irq_armed     = 1'b0;
      irq_raised    = 1'b0;
      rom_count_cfg = PRG_BANK_COUNT_RST;
   endfunction

   function automatic void apply_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_PRG_BANK_COUNT) begin
         rom_count_cfg = val;
      end else if (idx == CSR_MIRROR_AT_RESET) begin
         // strap write also loads the live mirroring
         mirror_h = val[0];
      end
   endfunction

   // 8 KB windows; fixed banks wrap at 64
   function automatic logic [OFFSET_W-1:0] prg_rom_offset(logic [ADDR_W-1:0] a);
      logic [PRG_BANK_W-1:0] top_bank;
      logic [PRG_BANK_W-1:0] next_to_top;
      logic [PRG_BANK_W-1:0] bank;
      top_bank    = {rom_count_cfg[4:0], 1'b0} - 6'd1;
      next_to_top = {rom_count_cfg[4:0], 1'b0} - 6'd2;
      case (a[14:13])
         WIN_8000: bank = prg_swapped ? next_to_top : bank_file[6][5:0];
         WIN_A000: bank = bank_file[7][5:0];
         WIN_C000: bank = prg_swapped ? bank_file[6][5:0] : next_to_top;
         default:  bank = top_bank;
      endcase
      return OFFSET_W'({bank, a[12:0]}) & OFFSET_W'((1 << PRG_BITS) - 1);
   endfunction

   // 1 KB windows; the low half pairs R0/R1 as even bank then even+1
   function automatic logic [OFFSET_W-1:0] chr_offset_of(logic [ADDR_W-1:0] a);
      logic [2:0] win;
      logic [7:0] bank;
      win = a[12:10] ^ {chr_inverted, 2'b00};
      if (!win[2]) begin
         bank = {bank_file[{2'b00, win[1]}][7:1], 1'b0} + {7'd0, win[0]};
      end else begin
         bank = bank_file[win - 3'd2];
      end
      return OFFSET_W'({bank, a[9:0]}) & OFFSET_W'((1 << CHR_BITS) - 1);
   endfunction

   function automatic void apply_reg_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
      case (a[14:13])
         GRP_BANK: begin
            if (a[0]) begin
               bank_file[bank_sel] = d;
            end else begin
               bank_sel     = d[2:0];
               prg_swapped  = d[6];
               chr_inverted = d[7];
            end
         end
         GRP_MIRROR: begin
            // odd address (RAM protect) has no effect here
            if (!a[0]) mirror_h = d[0];
         end
         GRP_RELOAD: begin
            if (a[0]) line_count = '0;
            else line_reload = d;
         end
         default: begin
            if (a[0]) begin
               irq_armed = 1'b1;
            end else begin
               irq_armed  = 1'b0;
               irq_raised = 1'b0;
            end
         end
      endcase
   endfunction

   function automatic void clock_scanline();
      if (line_count == 8'd0) line_count = line_reload;
      else line_count = line_count - 8'd1;
      if (line_count == 8'd0 && irq_armed) irq_raised = 1'b1;
   endfunction

   function automatic rsp_type predict_access(req_type r);
      rsp_type p;
      p = '0;
      case (r.func)
         FUNC_CPU_READ, FUNC_CPU_WRITE: begin
            if (r.bus_addr[15:13] == 3'b011) begin
               p.mem_select = SEL_PRG_RAM;
               p.mem_offset = OFFSET_W'(r.bus_addr[12:0]);
               p.mem_write  = (r.func == FUNC_CPU_WRITE);
            end else if (r.bus_addr[15]) begin
               if (r.func == FUNC_CPU_READ) begin
                  p.mem_select = SEL_PRG_ROM;
                  p.mem_offset = prg_rom_offset(r.bus_addr);
               end else begin
                  apply_reg_write(r.bus_addr, r.write_data);
               end
            end
         end
         FUNC_PPU_READ, FUNC_PPU_WRITE: begin
            if (r.bus_addr < 16'h2000) begin
               p.mem_select = SEL_CHR;
               p.mem_offset = chr_offset_of(r.bus_addr);
               p.mem_write  = (r.func == FUNC_PPU_WRITE);
            end
         end
         FUNC_SCANLINE: clock_scanline();
         default: ;
      endcase
      p.mirror_horizontal = mirror_h;
      p.irq_line          = irq_raised;
      return p;
   endfunction

   // ---------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(string what);
      if (mismatch_count < MAX_REPORTS) $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.mem_select !== want.mem_select)
               report_mismatch($sformatf("mem_select got %0d want %0d",
                                         rsp_data.mem_select, want.mem_select));
            if (rsp_data.mem_offset !== want.mem_offset)
               report_mismatch($sformatf("mem_offset got %05h want %05h",
                                         rsp_data.mem_offset, want.mem_offset));
            if (rsp_data.mem_write !== want.mem_write)
               report_mismatch($sformatf("mem_write got %b want %b",
                                         rsp_data.mem_write, want.mem_write));
            if (rsp_data.mirror_horizontal !== want.mirror_horizontal)
               report_mismatch($sformatf("mirror_horizontal got %b want %b",
                                         rsp_data.mirror_horizontal, want.mirror_horizontal));
            if (rsp_data.irq_line !== want.irq_line)
               report_mismatch($sformatf("irq_line got %b want %b",
                                         rsp_data.irq_line, want.irq_line));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bank_switch_mapper_with_scanline_irq test failed");
         $finish;
      end
   end

   // Receiver: long hold-off when requested, otherwise random stalls
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off  <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   // One request transfer; bursts with random gaps when gaps_on
   task automatic send_access(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                              logic [DATA_W-1:0] d);
      req_type r;
      r.func       = f;
      r.bus_addr   = a;
      r.write_data = d;
      @(negedge clock);
      if (gaps_on && burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(predict_access(r));
      burst_left--;
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_config(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_access();
      int                pick;
      logic [ADDR_W-1:0] a;
      logic [DATA_W-1:0] d;
      pick = $urandom_range(0, 99);
      a    = 16'($urandom);
      d    = 8'($urandom);
      if (pick < 25) begin
         send_access(FUNC_CPU_READ, {1'b1, a[14:0]}, d);
      end else if (pick < 33) begin
         send_access(d[0] ? FUNC_CPU_WRITE : FUNC_CPU_READ, {3'b011, a[12:0]}, d);
      end else if (pick < 55) begin
         send_access(d[1] ? FUNC_PPU_WRITE : FUNC_PPU_READ, {3'b000, a[12:0]}, d);
      end else if (pick < 70) begin
         // small reload values keep the IRQ firing often
         if (a[14:13] == GRP_RELOAD && !a[0] && $urandom_range(0, 9) < 6)
            d = 8'($urandom_range(0, 8));
         send_access(FUNC_CPU_WRITE, {1'b1, a[14:0]}, d);
      end else if (pick < 82) begin
         send_access(FUNC_SCANLINE, a, d);
      end else begin
         send_access(FUNC_W'($urandom), a, d);
      end
   endtask

   // Bank select, bank data, then a read through the new mapping
   task automatic send_bank_program();
      logic [ADDR_W-1:0] a;
      a = 16'($urandom);
      send_access(FUNC_CPU_WRITE, 16'h8000 | (a & 16'h1FFE), 8'($urandom));
      send_access(FUNC_CPU_WRITE, 16'h8001 | (16'($urandom) & 16'h1FFE), 8'($urandom));
      if (a[15]) send_access(FUNC_CPU_READ, {1'b1, a[14:0]}, 8'($urandom));
      else send_access(FUNC_PPU_READ, {3'b000, a[12:0]}, 8'($urandom));
   endtask

   // Reload, clear, enable, tick through zero, sometimes acknowledge
   task automatic send_irq_sequence();
      int n;
      n = $urandom_range(0, 6);
      send_access(FUNC_CPU_WRITE, 16'hC000 | (16'($urandom) & 16'h1FFE), 8'(n));
      send_access(FUNC_CPU_WRITE, 16'hC001 | (16'($urandom) & 16'h1FFE), 8'($urandom));
      send_access(FUNC_CPU_WRITE, 16'hE001 | (16'($urandom) & 16'h1FFE), 8'($urandom));
      repeat (n + 2) send_access(FUNC_SCANLINE, 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 1))
         send_access(FUNC_CPU_WRITE, 16'hE000 | (16'($urandom) & 16'h1FFE), 8'($urandom));
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_reset_defaults();
      send_access(FUNC_CPU_READ, 16'h8000, 8'h00);
      send_access(FUNC_CPU_READ, 16'hC000, 8'h00);
      send_access(FUNC_CPU_READ, 16'hFFFF, 8'h00);
      send_access(FUNC_PPU_READ, 16'h1FFF, 8'h00);
   endtask

   task automatic test_register_decode();
      int f;
      // PRG swap and CHR inversion on, then R7 loaded with all ones
      send_access(FUNC_CPU_WRITE, 16'h8000, 8'hC7);
      send_access(FUNC_CPU_WRITE, 16'h8001, 8'hFF);
      send_access(FUNC_CPU_READ, 16'h8000, 8'h00);
      send_access(FUNC_CPU_READ, 16'hA000, 8'h00);
      send_access(FUNC_CPU_READ, 16'hDFFF, 8'h00);
      send_access(FUNC_PPU_WRITE, 16'h0000, 8'h5A);
      // R0 all ones, odd CHR half-bank
      send_access(FUNC_CPU_WRITE, 16'h9FFE, 8'h00);
      send_access(FUNC_CPU_WRITE, 16'h9FFF, 8'hFF);
      send_access(FUNC_PPU_READ, 16'h07FF, 8'h00);
      // mirroring, and the ignored odd address in that range
      send_access(FUNC_CPU_WRITE, 16'hA000, 8'h01);
      send_access(FUNC_CPU_WRITE, 16'hA001, 8'h00);
      // PRG RAM and unmapped accesses
      send_access(FUNC_CPU_WRITE, 16'h6000, 8'hAA);
      send_access(FUNC_CPU_READ, 16'h7FFF, 8'h00);
      send_access(FUNC_CPU_WRITE, 16'h5FFF, 8'hFF);
      send_access(FUNC_PPU_READ, 16'h2000, 8'h00);
      send_access(FUNC_PPU_WRITE, 16'hFFFF, 8'hFF);
      // unused function codes
      for (f = int'(FUNC_SCANLINE) + 1; f < 2 ** FUNC_W; f++)
         send_access(FUNC_W'(f), 16'hFFFF, 8'hFF);
   endtask

   task automatic test_scanline_irq();
      send_access(FUNC_CPU_WRITE, 16'hC000, 8'h01);
      send_access(FUNC_CPU_WRITE, 16'hC001, 8'h00);
      send_access(FUNC_CPU_WRITE, 16'hE001, 8'h00);
      send_access(FUNC_SCANLINE, 16'h0000, 8'h00);
      send_access(FUNC_SCANLINE, 16'hFFFF, 8'hFF);
      send_access(FUNC_CPU_WRITE, 16'hE000, 8'h00);
   endtask

   // Receiver holds off while the sender keeps offering transfers
   task automatic test_backpressure();
      gaps_on   = 1'b0;
      stall_pct = 0;
      hold_off  = 80;
      repeat (30) send_random_access();
   endtask

   task automatic run_traffic_phase(logic [PRG_BANK_W-1:0] banks, logic strap,
                                    int stall, bit gapped, int count);
      int stop_at;
      int pick;
      write_csr(CSR_PRG_BANK_COUNT, CSR_DATA_W'(banks));
      write_csr(CSR_MIRROR_AT_RESET, CSR_DATA_W'(strap));
      stall_pct  = stall;
      gaps_on    = gapped;
      burst_left = 0;
      stop_at    = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) send_bank_program();
         else if (pick < 20) send_irq_sequence();
         else send_random_access();
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(6'd1, 1'b0, 30, 1'b1, 100);
      run_traffic_phase(6'd32, 1'b1, 0, 1'b0, 100);
      run_traffic_phase(6'd0, 1'b0, 60, 1'b1, 100);
      run_traffic_phase(6'd63, 1'b1, 20, 1'b0, 100);
      run_traffic_phase(6'($urandom_range(1, 32)), 1'($urandom), 40, 1'b1, 100);
      run_traffic_phase(PRG_BANK_COUNT_RST, 1'b0, 10, 1'b1, 100);
   endtask

   task automatic finish_run();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_rsp.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsp.size()));
      repeat (10) @(posedge clock);
   endtask

   initial begin
      reset_shadow();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_decode();
      test_scanline_irq();
      test_backpressure();
      test_random_traffic();
      finish_run();
      if (mismatch_count == 0) begin
         $display("bank_switch_mapper_with_scanline_irq test passed");
      end else begin
         $display("bank_switch_mapper_with_scanline_irq test failed");
      end
      $finish;
   end

endmodule
